>>> rtl/tgc_pkg.sv
// Shared constants, types and helper functions of the touch gesture classifier.
// No dependencies; compiled first.
`default_nettype none

package tgc_pkg;

  // screen geometry and raw controller span
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int RAW_SPAN      = 240;

  // field widths
  localparam int RAW_W  = 12;
  localparam int CNT_W  = 4;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int PX_W   = 9;
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int SQ_W   = 18;
  localparam int G_W    = 3;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  typedef enum logic [G_W-1:0] {
    G_NONE   = 3'd0,
    G_TAP    = 3'd1,
    G_LONG   = 3'd2,
    G_SWIPE  = 3'd3,
    G_DOUBLE = 3'd4
  } gesture_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MULTI_TAP_GAP = 3'd0,
    REG_LONG_PRESS    = 3'd1,
    REG_STILL_TOL     = 3'd2,
    REG_SWIPE_MIN     = 3'd3,
    REG_SWIPE_MAX     = 3'd4,
    REG_TAP_MAX       = 3'd5,
    REG_MULTI_TAP_RAD = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [MS_W-1:0] RST_MULTI_TAP_GAP = 16'd300;
  localparam logic [MS_W-1:0] RST_LONG_PRESS    = 16'd600;
  localparam logic [PX_W-1:0] RST_STILL_TOL     = 9'd12;
  localparam logic [PX_W-1:0] RST_SWIPE_MIN     = 9'd40;
  localparam logic [MS_W-1:0] RST_SWIPE_MAX     = 16'd500;
  localparam logic [MS_W-1:0] RST_TAP_MAX       = 16'd300;
  localparam logic [PX_W-1:0] RST_MULTI_TAP_RAD = 9'd30;

  function automatic logic [SQ_W-1:0] sq_px(input logic [PX_W-1:0] v);
    logic [2*PX_W-1:0] p;
    p = v * v;
    return p[SQ_W-1:0];
  endfunction

  // squared distance between two screen points; fits 18 bits on screen
  function automatic logic [SQ_W-1:0] dist_sq(input logic [X_W-1:0] ax,
                                              input logic [Y_W-1:0] ay,
                                              input logic [X_W-1:0] bx,
                                              input logic [Y_W-1:0] by);
    logic [X_W-1:0]   dx;
    logic [Y_W-1:0]   dy;
    logic [2*X_W-1:0] dx2;
    logic [2*Y_W-1:0] dy2;
    logic [SQ_W:0]    s;
    dx  = (ax > bx) ? ax - bx : bx - ax;
    dy  = (ay > by) ? ay - by : by - ay;
    dx2 = dx * dx;
    dy2 = dy * dy;
    s   = (SQ_W+1)'(dx2) + (SQ_W+1)'(dy2);
    return s[SQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tgc_sample_if.sv
// Input channel of the touch gesture classifier: one tick with an optional sample.
// Depends on tgc_pkg for field widths.
`default_nettype none

interface tgc_sample_if;
  import tgc_pkg::*;

  logic              valid;
  logic              ready;
  logic              has_sample;
  logic [CNT_W-1:0]  finger_count;
  logic [RAW_W-1:0]  raw_x;
  logic [RAW_W-1:0]  raw_y;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, has_sample, finger_count, raw_x, raw_y, now_ms,
                  input ready);
  modport sink (input valid, has_sample, finger_count, raw_x, raw_y, now_ms,
                output ready);
endinterface

`default_nettype wire

>>> rtl/tgc_result_if.sv
// Result channel of the touch gesture classifier: gesture code and position.
// Depends on tgc_pkg for field widths.
`default_nettype none

interface tgc_result_if;
  import tgc_pkg::*;

  logic           valid;
  logic           ready;
  logic [G_W-1:0] gesture;
  logic [X_W-1:0] pos_x;
  logic [Y_W-1:0] pos_y;

  modport source (output valid, gesture, pos_x, pos_y, input ready);
  modport sink (input valid, gesture, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

>>> rtl/touch_gesture_classifier_core.sv
// Touch gesture classifier core: APB register file, input register and classifier step.
// Depends on tgc_pkg, tgc_sample_if and tgc_result_if.
//
// Each accepted tick gives exactly one result (gesture none when nothing happened).
// The block takes one tick per cycle while the result channel is not stalled. An accepted
// tick is rotated and clamped into an input register, and the whole classifier step
// (squared distances, time compares, state update) is combinational between that register
// and the result register. When the result is not taken, the input register still
// holds one more tick before ready drops. Registers sit at byte address 4*i; the user must
// see that they are written only while the block is idle, which the block does not enforce.
`default_nettype none

module touch_gesture_classifier_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tgc_pkg::CFG_AW-1:0]  paddr,
  input  logic [tgc_pkg::DATA_W-1:0]  pwdata,
  output logic [tgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  tgc_sample_if.sink                  sample,
  tgc_result_if.source                result
);
  import tgc_pkg::*;

  // configuration registers
  logic [MS_W-1:0] multi_tap_gap_ms;
  logic [MS_W-1:0] long_press_ms;
  logic [PX_W-1:0] still_tolerance_px;
  logic [PX_W-1:0] swipe_min_px;
  logic [MS_W-1:0] swipe_max_ms;
  logic [MS_W-1:0] tap_max_ms;
  logic [PX_W-1:0] multi_tap_radius_px;
  // squared thresholds, kept alongside their registers
  logic [SQ_W-1:0] still_sq;
  logic [SQ_W-1:0] swipe_min_sq;
  logic [SQ_W-1:0] radius_sq;

  logic     cfg_wr;
  reg_idx_t cfg_sel;
  logic [PX_W-1:0] wdata_px;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_sel  = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wdata_px = pwdata[PX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      multi_tap_gap_ms    <= RST_MULTI_TAP_GAP;
      long_press_ms       <= RST_LONG_PRESS;
      still_tolerance_px  <= RST_STILL_TOL;
      swipe_min_px        <= RST_SWIPE_MIN;
      swipe_max_ms        <= RST_SWIPE_MAX;
      tap_max_ms          <= RST_TAP_MAX;
      multi_tap_radius_px <= RST_MULTI_TAP_RAD;
      still_sq            <= sq_px(RST_STILL_TOL);
      swipe_min_sq        <= sq_px(RST_SWIPE_MIN);
      radius_sq           <= sq_px(RST_MULTI_TAP_RAD);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MULTI_TAP_GAP: multi_tap_gap_ms <= pwdata[MS_W-1:0];
        REG_LONG_PRESS:    long_press_ms    <= pwdata[MS_W-1:0];
        REG_STILL_TOL: begin
          still_tolerance_px <= wdata_px;
          still_sq           <= sq_px(wdata_px);
        end
        REG_SWIPE_MIN: begin
          swipe_min_px <= wdata_px;
          swipe_min_sq <= sq_px(wdata_px);
        end
        REG_SWIPE_MAX:     swipe_max_ms <= pwdata[MS_W-1:0];
        REG_TAP_MAX:       tap_max_ms   <= pwdata[MS_W-1:0];
        REG_MULTI_TAP_RAD: begin
          multi_tap_radius_px <= wdata_px;
          radius_sq           <= sq_px(wdata_px);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MULTI_TAP_GAP: prdata = DATA_W'(multi_tap_gap_ms);
      REG_LONG_PRESS:    prdata = DATA_W'(long_press_ms);
      REG_STILL_TOL:     prdata = DATA_W'(still_tolerance_px);
      REG_SWIPE_MIN:     prdata = DATA_W'(swipe_min_px);
      REG_SWIPE_MAX:     prdata = DATA_W'(swipe_max_ms);
      REG_TAP_MAX:       prdata = DATA_W'(tap_max_ms);
      REG_MULTI_TAP_RAD: prdata = DATA_W'(multi_tap_radius_px);
      default:           prdata = '0;
    endcase
  end

  // rotation and clamping of the raw sample
  localparam logic [RAW_W:0]   SPAN   = (RAW_W+1)'(RAW_SPAN);
  localparam logic [RAW_W:0]   X_LAST = (RAW_W+1)'(SCREEN_WIDTH - 1);
  localparam logic [RAW_W:0]   Y_LAST = (RAW_W+1)'(SCREEN_HEIGHT - 1);

  logic           map_touched;
  logic [X_W-1:0] map_x;
  logic [Y_W-1:0] map_y;
  logic [RAW_W:0] y_diff;

  always_comb begin
    map_touched = sample.finger_count inside {4'd1, 4'd2};
    if ((RAW_W+1)'(sample.raw_y) > X_LAST) map_x = X_LAST[X_W-1:0];
    else                                   map_x = sample.raw_y[X_W-1:0];
    y_diff = SPAN - (RAW_W+1)'(sample.raw_x);
    if ((RAW_W+1)'(sample.raw_x) >= SPAN) map_y = '0;
    else if (y_diff > Y_LAST)             map_y = Y_LAST[Y_W-1:0];
    else                                  map_y = y_diff[Y_W-1:0];
  end

  // input register
  logic              s_valid;
  logic              s_has;
  logic              s_touched;
  logic [X_W-1:0]    s_cx;
  logic [Y_W-1:0]    s_cy;
  logic [TIME_W-1:0] s_now;

  logic out_valid;
  logic adv;

  assign adv          = s_valid && (!out_valid || result.ready);
  assign sample.ready = !s_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_has     <= sample.has_sample;
      s_touched <= map_touched;
      s_cx      <= map_x;
      s_cy      <= map_y;
      s_now     <= sample.now_ms;
    end
  end

  // classifier state
  logic              is_pressed, is_pressed_next;
  logic              long_sent, long_sent_next;
  logic              tap_pending, tap_pending_next;
  logic              wait_release, wait_release_next;
  logic [TIME_W-1:0] press_start_time, press_start_time_next;
  logic [TIME_W-1:0] tap_release_time, tap_release_time_next;
  logic [X_W-1:0]    press_x, press_x_next;
  logic [Y_W-1:0]    press_y, press_y_next;
  logic [X_W-1:0]    latest_x, latest_x_next;
  logic [Y_W-1:0]    latest_y, latest_y_next;
  logic [X_W-1:0]    tap_x, tap_x_next;
  logic [Y_W-1:0]    tap_y, tap_y_next;
  logic [SQ_W-1:0]   max_move_sq, max_move_sq_next;

  gesture_t          g;
  logic [X_W-1:0]    ox;
  logic [Y_W-1:0]    oy;
  logic [TIME_W-1:0] since_tap;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] held_new;
  logic [SQ_W-1:0]   d_press;
  logic [SQ_W-1:0]   d_tap;

  assign since_tap = s_now - tap_release_time;
  assign held      = s_now - press_start_time;
  assign d_press   = dist_sq(press_x, press_y, s_cx, s_cy);
  assign d_tap     = dist_sq(tap_x, tap_y, latest_x, latest_y);

  always_comb begin
    is_pressed_next       = is_pressed;
    long_sent_next        = long_sent;
    tap_pending_next      = tap_pending;
    wait_release_next     = wait_release;
    press_start_time_next = press_start_time;
    tap_release_time_next = tap_release_time;
    press_x_next          = press_x;
    press_y_next          = press_y;
    latest_x_next         = latest_x;
    latest_y_next         = latest_y;
    tap_x_next            = tap_x;
    tap_y_next            = tap_y;
    max_move_sq_next      = max_move_sq;
    g                     = G_NONE;
    ox                    = '0;
    oy                    = '0;
    held_new              = '0;

    if (tap_pending && !is_pressed && since_tap > TIME_W'(multi_tap_gap_ms)) begin
      // expiring tap wins, the sample of this tick is dropped
      tap_pending_next = 1'b0;
      g  = G_TAP;
      ox = tap_x;
      oy = tap_y;
    end else if (!s_has) begin
      g = G_NONE;
    end else if (wait_release) begin
      if (!s_touched) wait_release_next = 1'b0;
    end else if (s_touched) begin
      if (!is_pressed) begin
        is_pressed_next       = 1'b1;
        long_sent_next        = 1'b0;
        press_start_time_next = s_now;
        press_x_next          = s_cx;
        press_y_next          = s_cy;
        latest_x_next         = s_cx;
        latest_y_next         = s_cy;
        max_move_sq_next      = '0;
      end else begin
        latest_x_next = s_cx;
        latest_y_next = s_cy;
        if (d_press > max_move_sq) max_move_sq_next = d_press;
      end
      held_new = s_now - press_start_time_next;
      if (!long_sent_next && held_new >= TIME_W'(long_press_ms) &&
          max_move_sq_next <= still_sq) begin
        long_sent_next   = 1'b1;
        tap_pending_next = 1'b0;
        g  = G_LONG;
        ox = latest_x_next;
        oy = latest_y_next;
      end
    end else if (is_pressed) begin
      // release
      is_pressed_next = 1'b0;
      if (long_sent) begin
        g = G_NONE;
      end else if (held <= TIME_W'(swipe_max_ms) && max_move_sq >= swipe_min_sq) begin
        tap_pending_next = 1'b0;
        g  = G_SWIPE;
        ox = latest_x;
        oy = latest_y;
      end else if (held > TIME_W'(tap_max_ms) || max_move_sq > still_sq) begin
        g = G_NONE;
      end else if (tap_pending && since_tap <= TIME_W'(multi_tap_gap_ms) &&
                   d_tap <= radius_sq) begin
        tap_pending_next  = 1'b0;
        wait_release_next = 1'b1;
        g  = G_DOUBLE;
        ox = latest_x;
        oy = latest_y;
      end else begin
        tap_pending_next      = 1'b1;
        tap_release_time_next = s_now;
        tap_x_next            = latest_x;
        tap_y_next            = latest_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed       <= 1'b0;
      long_sent        <= 1'b0;
      tap_pending      <= 1'b0;
      wait_release     <= 1'b0;
      press_start_time <= '0;
      tap_release_time <= '0;
      press_x          <= '0;
      press_y          <= '0;
      latest_x         <= '0;
      latest_y         <= '0;
      tap_x            <= '0;
      tap_y            <= '0;
      max_move_sq      <= '0;
    end else if (adv) begin
      is_pressed       <= is_pressed_next;
      long_sent        <= long_sent_next;
      tap_pending      <= tap_pending_next;
      wait_release     <= wait_release_next;
      press_start_time <= press_start_time_next;
      tap_release_time <= tap_release_time_next;
      press_x          <= press_x_next;
      press_y          <= press_y_next;
      latest_x         <= latest_x_next;
      latest_y         <= latest_y_next;
      tap_x            <= tap_x_next;
      tap_y            <= tap_y_next;
      max_move_sq      <= max_move_sq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.gesture <= g;
      result.pos_x   <= ox;
      result.pos_y   <= oy;
    end
  end

  assign result.valid = out_valid;

  // checks
  a_none_at_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.gesture == G_NONE |-> result.pos_x == '0 && result.pos_y == '0)
    else $error("gesture none with nonzero position");

  a_pos_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SQ_W)'(result.pos_x) < (SQ_W)'(SCREEN_WIDTH) &&
                  (SQ_W)'(result.pos_y) < (SQ_W)'(SCREEN_HEIGHT))
    else $error("result position off screen");

  a_wait_no_tap: assert property (@(posedge clk) disable iff (rst)
    wait_release |-> !tap_pending && !is_pressed)
    else $error("waiting for release with a tap pending or a press held");

  a_stall_holds_tick: assert property (@(posedge clk) disable iff (rst)
    s_valid && out_valid && !result.ready |=> s_valid && out_valid)
    else $error("tick lost while result stalled");

  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    adv && g == G_LONG |=> is_pressed && long_sent)
    else $error("long press reported without a held press");

endmodule

`default_nettype wire

>>> tb/tgc_gesture_checker.sv
// Checker for the touch gesture classifier: watches the register port and both channels,
// predicts one gesture result per accepted request and compares it with the result channel.
// Depends on tgc_pkg, tgc_sample_if and tgc_result_if.
module tgc_gesture_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tgc_pkg::CFG_AW-1:0] paddr,
  input  logic [tgc_pkg::DATA_W-1:0] pwdata,
  tgc_sample_if                      sample,
  tgc_result_if                      result,
  output int                         error_count,
  output int                         pending_results
);
  import tgc_pkg::*;

  typedef struct packed {
    gesture_t       gesture;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } gesture_rec_t;

  gesture_rec_t expected_gestures[$];

  // thresholds as last written
  int unsigned gap_ms, long_ms, still_px, swipe_min_px, swipe_max_ms, tap_max_ms, radius_px;

  // tracker state
  logic              held_down, long_fired, tap_armed, ignore_until_lift;
  logic [TIME_W-1:0] press_t0, tap_t;
  int unsigned       start_x, start_y, cur_x, cur_y, peak_move_sq, tap_px, tap_py;

  initial begin
    error_count     = 0;
    pending_results = 0;
  end

  function automatic gesture_rec_t make_rec(input gesture_t g, input int unsigned x,
                                            input int unsigned y);
    gesture_rec_t r;
    r.gesture = g;
    r.x       = X_W'(x);
    r.y       = Y_W'(y);
    return r;
  endfunction

  function automatic int unsigned span_sq(input int unsigned ax, input int unsigned ay,
                                          input int unsigned bx, input int unsigned by);
    int unsigned dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic gesture_rec_t classify_tick(input logic has, input logic [CNT_W-1:0] fingers,
                                                 input logic [RAW_W-1:0] rx,
                                                 input logic [RAW_W-1:0] ry,
                                                 input logic [TIME_W-1:0] now);
    logic              touching;
    int                cx, cy;
    int unsigned       still_sq, m;
    logic [TIME_W-1:0] held;
    // a pending tap that has run out wins and swallows the sample
    if (tap_armed && !held_down && (now - tap_t) > gap_ms) begin
      tap_armed = 1'b0;
      return make_rec(G_TAP, tap_px, tap_py);
    end
    if (!has) return make_rec(G_NONE, 0, 0);
    touching = (fingers == 4'd1) || (fingers == 4'd2);
    if (ignore_until_lift) begin
      if (!touching) ignore_until_lift = 1'b0;
      return make_rec(G_NONE, 0, 0);
    end
    still_sq = still_px * still_px;
    if (touching) begin
      cx = int'(ry);
      if (cx > SCREEN_WIDTH - 1) cx = SCREEN_WIDTH - 1;
      cy = RAW_SPAN - int'(rx);
      if (cy < 0) cy = 0;
      if (cy > SCREEN_HEIGHT - 1) cy = SCREEN_HEIGHT - 1;
      if (!held_down) begin
        held_down    = 1'b1;
        long_fired   = 1'b0;
        press_t0     = now;
        start_x      = cx;
        start_y      = cy;
        cur_x        = cx;
        cur_y        = cy;
        peak_move_sq = 0;
      end else begin
        cur_x = cx;
        cur_y = cy;
        m = span_sq(start_x, start_y, cur_x, cur_y);
        if (m > peak_move_sq) peak_move_sq = m;
      end
      if (!long_fired && (now - press_t0) >= long_ms && peak_move_sq <= still_sq) begin
        long_fired = 1'b1;
        tap_armed  = 1'b0;
        return make_rec(G_LONG, cur_x, cur_y);
      end
      return make_rec(G_NONE, 0, 0);
    end
    if (!held_down) return make_rec(G_NONE, 0, 0);
    held_down = 1'b0;
    if (long_fired) return make_rec(G_NONE, 0, 0);
    held = now - press_t0;
    if (held <= swipe_max_ms && peak_move_sq >= swipe_min_px * swipe_min_px) begin
      tap_armed = 1'b0;
      return make_rec(G_SWIPE, cur_x, cur_y);
    end
    if (held > tap_max_ms || peak_move_sq > still_sq) return make_rec(G_NONE, 0, 0);
    if (tap_armed && (now - tap_t) <= gap_ms
        && span_sq(tap_px, tap_py, cur_x, cur_y) <= radius_px * radius_px) begin
      tap_armed         = 1'b0;
      ignore_until_lift = 1'b1;
      return make_rec(G_DOUBLE, cur_x, cur_y);
    end
    tap_armed = 1'b1;
    tap_t     = now;
    tap_px    = cur_x;
    tap_py    = cur_y;
    return make_rec(G_NONE, 0, 0);
  endfunction

  always @(posedge clk) begin : watch
    gesture_rec_t want;
    int           errs;
    errs = 0;
    if (rst) begin
      gap_ms            = RST_MULTI_TAP_GAP;
      long_ms           = RST_LONG_PRESS;
      still_px          = RST_STILL_TOL;
      swipe_min_px      = RST_SWIPE_MIN;
      swipe_max_ms      = RST_SWIPE_MAX;
      tap_max_ms        = RST_TAP_MAX;
      radius_px         = RST_MULTI_TAP_RAD;
      held_down         = 1'b0;
      long_fired        = 1'b0;
      tap_armed         = 1'b0;
      ignore_until_lift = 1'b0;
      press_t0          = '0;
      tap_t             = '0;
      start_x           = 0;
      start_y           = 0;
      cur_x             = 0;
      cur_y             = 0;
      peak_move_sq      = 0;
      tap_px            = 0;
      tap_py            = 0;
      expected_gestures.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_AW-1:2]))
          REG_MULTI_TAP_GAP: gap_ms       = pwdata[MS_W-1:0];
          REG_LONG_PRESS:    long_ms      = pwdata[MS_W-1:0];
          REG_STILL_TOL:     still_px     = pwdata[PX_W-1:0];
          REG_SWIPE_MIN:     swipe_min_px = pwdata[PX_W-1:0];
          REG_SWIPE_MAX:     swipe_max_ms = pwdata[MS_W-1:0];
          REG_TAP_MAX:       tap_max_ms   = pwdata[MS_W-1:0];
          REG_MULTI_TAP_RAD: radius_px    = pwdata[PX_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing: a result never belongs to a request of the same edge
      if (result.valid && result.ready) begin
        if (expected_gestures.size() == 0) begin
          $error("unexpected result: gesture %0d at (%0d,%0d) with no request pending",
                 result.gesture, result.pos_x, result.pos_y);
          errs++;
        end else begin
          want = expected_gestures.pop_front();
          if (result.gesture !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, result.gesture);
            errs++;
          end
          if (result.pos_x !== want.x) begin
            $error("pos_x: expected %0d, got %0d", want.x, result.pos_x);
            errs++;
          end
          if (result.pos_y !== want.y) begin
            $error("pos_y: expected %0d, got %0d", want.y, result.pos_y);
            errs++;
          end
        end
      end
      if (sample.valid && sample.ready)
        expected_gestures.push_back(classify_tick(sample.has_sample, sample.finger_count,
                                                  sample.raw_x, sample.raw_y, sample.now_ms));
    end
    error_count     <= error_count + errs;
    pending_results <= expected_gestures.size();
  end

endmodule

>>> tb/touch_gesture_classifier_core_test.sv
// Top of the touch gesture classifier test: clock, reset, register writes, tick stimulus
// and the verdict. Depends on tgc_pkg, both channel interfaces and tgc_gesture_checker.
module touch_gesture_classifier_core_test;
  import tgc_pkg::*;

  localparam int GESTURE_ITEMS = 1950;
  localparam int PHASES        = 6;
  localparam int STALL_LIMIT   = 2000;

  logic              clk, rst;
  logic              psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int                error_count, pending_results;

  tgc_sample_if smp();
  tgc_result_if res();

  touch_gesture_classifier_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (smp),
    .result  (res)
  );

  tgc_gesture_checker chk (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .sample          (smp),
    .result          (res),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  logic [TIME_W-1:0] ms_now;
  int ticks_sent = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  // thresholds as written, used to time the strokes
  int gap_ms, long_ms, tol_px, swmin_px, swmax_ms, tapmax_ms, rad_px;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready = quiet || ($urandom_range(99) >= 22);
    end
  end

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int fit(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [RAW_W-1:0] raw_y_for(input int x);
    if (x == SCREEN_WIDTH - 1 && $urandom_range(1)) return RAW_W'($urandom_range(319, 4095));
    return RAW_W'(x);
  endfunction

  function automatic logic [RAW_W-1:0] raw_x_for(input int y);
    if (y == 0 && $urandom_range(1)) return RAW_W'($urandom_range(240, 4095));
    if (y == SCREEN_HEIGHT - 1 && $urandom_range(1)) return '0;
    return RAW_W'(RAW_SPAN - y);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic has, input logic [CNT_W-1:0] fingers,
                           input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                           input logic [TIME_W-1:0] now);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        smp.valid = 1'b0;
        @(negedge clk);
      end
    end
    smp.valid        = 1'b1;
    smp.has_sample   = has;
    smp.finger_count = fingers;
    smp.raw_x        = rx;
    smp.raw_y        = ry;
    smp.now_ms       = now;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic send_touch(input int x, input int y, input logic [TIME_W-1:0] now);
    send_tick(1'b1, CNT_W'($urandom_range(1, 2)), raw_x_for(y), raw_y_for(x), now);
  endtask

  task automatic send_lift(input logic [TIME_W-1:0] now);
    send_tick(1'b1, $urandom_range(1) ? 4'd0 : CNT_W'($urandom_range(3, 15)),
              RAW_W'($urandom), RAW_W'($urandom), now);
  endtask

  task automatic send_empty(input logic [TIME_W-1:0] now);
    send_tick(1'b0, CNT_W'($urandom), RAW_W'($urandom), RAW_W'($urandom), now);
  endtask

  // press at p0, move toward p1 over hold ms in n samples, then lift
  task automatic stroke(input int x0, input int y0, input int x1, input int y1,
                        input longint hold, input int n, input int jit);
    logic [TIME_W-1:0] t0, t;
    int k, x, y, d;
    t0 = ms_now;
    d  = (n > 1) ? n - 1 : 1;
    for (k = 0; k < n; k++) begin
      x = x0 + (x1 - x0) * k / d;
      y = y0 + (y1 - y0) * k / d;
      if (k != 0 && jit > 0) begin
        x = x + int'($urandom_range(0, 2 * jit)) - jit;
        y = y + int'($urandom_range(0, 2 * jit)) - jit;
      end
      t = t0 + TIME_W'(hold * k / n);
      if ($urandom_range(99) < 12) send_empty(t);
      send_touch(fit(x, SCREEN_WIDTH - 1), fit(y, SCREEN_HEIGHT - 1), t);
    end
    t = t0 + TIME_W'(hold);
    if ($urandom_range(99) < 12) send_empty(t);
    send_lift(t);
    ms_now = t;
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input int gap, input int lng, input int tol, input int smin,
                            input int smax, input int tmax, input int rad);
    gap_ms    = gap;
    long_ms   = lng;
    tol_px    = tol;
    swmin_px  = smin;
    swmax_ms  = smax;
    tapmax_ms = tmax;
    rad_px    = rad;
    // junk above the field width must be dropped by the register
    write_reg(REG_MULTI_TAP_GAP, gap | ($urandom << MS_W));
    write_reg(REG_LONG_PRESS, lng | ($urandom << MS_W));
    write_reg(REG_STILL_TOL, tol | ($urandom << PX_W));
    write_reg(REG_SWIPE_MIN, smin | ($urandom << PX_W));
    write_reg(REG_SWIPE_MAX, smax | ($urandom << MS_W));
    write_reg(REG_TAP_MAX, tmax | ($urandom << MS_W));
    write_reg(REG_MULTI_TAP_RAD, rad | ($urandom << PX_W));
  endtask

  task automatic hold_until_drained();
    smp.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_gesture();
    int kind, x0, y0, x1, y1, r, n, k;
    ms_now = ms_now + $urandom_range(1, 60);
    x0   = $urandom_range(0, SCREEN_WIDTH - 1);
    y0   = $urandom_range(0, SCREEN_HEIGHT - 1);
    kind = $urandom_range(99);
    if (kind < 22) begin
      // single tap, sometimes held a bit too long
      stroke(x0, y0, x0, y0, $urandom_range(0, tapmax_ms + tapmax_ms / 4 + 2),
             $urandom_range(1, 4), tol_px / 2);
    end else if (kind < 44) begin
      // double tap, then touches that must be ignored until the lift
      stroke(x0, y0, x0, y0, $urandom_range(0, tapmax_ms), $urandom_range(1, 3), tol_px / 2);
      ms_now = ms_now + $urandom_range(0, gap_ms / 2 + 1);
      r  = rad_px * 3 / 4;
      x1 = fit(x0 + int'($urandom_range(0, 2 * r)) - r, SCREEN_WIDTH - 1);
      y1 = fit(y0 + int'($urandom_range(0, 2 * r)) - r, SCREEN_HEIGHT - 1);
      stroke(x1, y1, x1, y1,
             $urandom_range(0, ((tapmax_ms < gap_ms / 2) ? tapmax_ms : gap_ms / 2) + 1),
             $urandom_range(1, 3), tol_px / 2);
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) begin
        ms_now = ms_now + $urandom_range(1, 30);
        send_touch($urandom_range(0, SCREEN_WIDTH - 1), $urandom_range(0, SCREEN_HEIGHT - 1),
                   ms_now);
      end
      ms_now = ms_now + $urandom_range(1, 20);
      send_lift(ms_now);
    end else if (kind < 58) begin
      // long press: the last touched sample lands past the hold time
      n = $urandom_range(2, 6);
      stroke(x0, y0, x0, y0, longint'(long_ms + $urandom_range(0, 300)) * n / (n - 1), n,
             tol_px / 2);
    end else if (kind < 74) begin
      r = swmin_px + $urandom_range(0, 60);
      if ($urandom_range(1)) begin
        x1 = x0 + ($urandom_range(1) ? r : -r);
        y1 = y0 + int'($urandom_range(0, 20)) - 10;
      end else begin
        x1 = x0 + int'($urandom_range(0, 20)) - 10;
        y1 = y0 + ($urandom_range(1) ? r : -r);
      end
      stroke(x0, y0, fit(x1, SCREEN_WIDTH - 1), fit(y1, SCREEN_HEIGHT - 1),
             $urandom_range(0, swmax_ms + swmax_ms / 4 + 1), $urandom_range(2, 5), 0);
    end else if (kind < 84) begin
      // drag that lands around the stillness radius
      r = tol_px * 2 + 5;
      stroke(x0, y0, fit(x0 + int'($urandom_range(0, 2 * r)) - r, SCREEN_WIDTH - 1),
             fit(y0 + int'($urandom_range(0, 2 * r)) - r, SCREEN_HEIGHT - 1),
             $urandom_range(0, long_ms + 10), $urandom_range(2, 6), 2);
    end else if (kind < 93) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        ms_now = ms_now + $urandom_range(0, gap_ms / 2 + 20);
        send_empty(ms_now);
      end
    end else begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        send_tick(1'($urandom), CNT_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                  ($urandom_range(7) == 0) ? TIME_W'($urandom)
                                           : ms_now + $urandom_range(0, 40));
    end
  endtask

  initial begin
    int ph, base;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    smp.valid        = 1'b0;
    smp.has_sample   = 1'b0;
    smp.finger_count = '0;
    smp.raw_x        = '0;
    smp.raw_y        = '0;
    smp.now_ms       = '0;
    ms_now           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_config(300, 600, 12, 40, 500, 300, 30);
    send_tick(1'b0, 4'hF, 12'hFFF, 12'hFFF, 32'd0);
    send_tick(1'b1, 4'd0, 12'd0, 12'd0, 32'd5);
    // clamped corners, then a fast move released with three fingers
    send_tick(1'b1, 4'd1, 12'd0, 12'hFFF, 32'd10);
    send_tick(1'b1, 4'd2, 12'hFFF, 12'd0, 32'd40);
    send_tick(1'b1, 4'd3, 12'd100, 12'd100, 32'd100);
    // double tap, then ignored touches until the lift
    send_tick(1'b1, 4'd1, 12'd140, 12'd100, 32'd200);
    send_tick(1'b1, 4'd15, 12'd0, 12'd0, 32'd250);
    send_tick(1'b1, 4'd2, 12'd140, 12'd105, 32'd300);
    send_tick(1'b1, 4'd0, 12'd140, 12'd105, 32'd350);
    send_tick(1'b1, 4'd2, 12'd5, 12'd5, 32'd360);
    send_tick(1'b1, 4'd1, 12'd3000, 12'd3000, 32'd370);
    send_tick(1'b1, 4'd0, 12'd0, 12'd0, 32'd380);
    // tap that expires on a touched sample, which is dropped
    send_tick(1'b1, 4'd1, 12'd190, 12'd50, 32'd400);
    send_tick(1'b1, 4'd7, 12'd0, 12'd0, 32'd420);
    send_tick(1'b0, 4'd0, 12'd0, 12'd0, 32'd600);
    send_tick(1'b1, 4'd1, 12'd190, 12'd50, 32'd800);
    // long press and its silent release
    send_tick(1'b1, 4'd1, 12'd190, 12'd50, 32'd810);
    send_tick(1'b1, 4'd2, 12'd190, 12'd52, 32'd1500);
    send_tick(1'b1, 4'd1, 12'd190, 12'd50, 32'd1600);
    send_tick(1'b1, 4'd0, 12'd0, 12'd0, 32'd1700);
    // tap across the time wrap
    send_tick(1'b1, 4'd1, 12'd230, 12'd200, 32'hFFFF_FFF0);
    send_tick(1'b1, 4'd0, 12'd0, 12'd0, 32'h0000_0020);
    send_tick(1'b0, 4'd0, 12'd0, 12'd0, 32'd333);

    base = ticks_sent;
    for (ph = 0; ph < PHASES; ph++) begin
      hold_until_drained();
      case (ph)
        1: set_config(0, 0, 0, 0, 0, 0, 0);
        2: set_config(65535, 65535, 511, 511, 65535, 65535, 511);
        3: set_config(300, 600, 12, 40, 500, 300, 30);
        default: set_config($urandom_range(50, 800), $urandom_range(100, 1500),
                            $urandom_range(0, 40), $urandom_range(10, 150),
                            $urandom_range(100, 900), $urandom_range(50, 500),
                            $urandom_range(5, 80));
      endcase
      quiet  = (ph == 4);
      ms_now = (ph == PHASES - 1) ? 32'hFFFF_FFFF - $urandom_range(0, 20000) : $urandom;
      while (ticks_sent < base + GESTURE_ITEMS * (ph + 1) / PHASES) run_gesture();
    end
    quiet = 1'b0;
    smp.valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
